FILE: hw/rtl/ppid_pkg.sv
package ppid_pkg;

  localparam int SUM_WIDTH = 32;

  localparam int DATA_W     = 16;
  localparam int ERR_W      = DATA_W + 1;
  localparam int DERR_W     = DATA_W + 2;
  localparam int CHUNK_W    = 16;
  localparam int SUM_CHUNKS = (SUM_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int SPAD_W     = SUM_CHUNKS * CHUNK_W;
  localparam int CNT_W      = $clog2(SUM_CHUNKS);

  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = ERR_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  localparam int CLAMP_EXP  = 60;
  localparam int IMAG_W     = CLAMP_EXP + 1;
  localparam int ACC_W      = 64;
  localparam int FRAC_W     = 16;
  localparam int P_SHIFT    = 8;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_GAIN_P           = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I           = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D           = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_SCALE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DERIVATIVE_SCALE = 3'd4;

  localparam logic [DATA_W-1:0] SCALE_RESET = 16'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_KI,
    ST_KD,
    ST_PROP,
    ST_INTEG,
    ST_APPLY_I,
    ST_DERIV,
    ST_FIN
  } pid_state_t;

endpackage

FILE: hw/rtl/positional_pid_controller_top.sv
// Positional PID controller for servo loops. Each request carries a measured
// position and a target position, and yields one 16-bit signed drive value
// Kp*e + Ki*Kimag*sum + Kd*Kdmag*de, with signed Q8.8 gains and unsigned Q8.8
// magnify factors, truncated toward zero and saturated. The integral sum
// saturates at SUM_WIDTH bits, and it and the previous error clear on reset.
// All products go through one shared 32x17 unsigned multiplier, so a request
// steps through EVAL, KI, KD, PROP, INTEG (once per 16-bit sum chunk), APPLY_I,
// DERIV and FIN, and in_stall is high until it is back in IDLE. The result sits in an
// output register, so a new request is accepted while the last one waits.
// Gains are written over the APB port at byte addresses 0, 4, 8, 12 and 16.
module positional_pid_controller_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              in_feedback,
  input  logic signed [15:0]              in_target,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [15:0]              out_drive,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ppid_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ppid_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ppid_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  import ppid_pkg::*;

  pid_state_t state_r, state_nxt;

  logic [DATA_W-1:0] gain_p_r, gain_i_r, gain_d_r, iscale_r, dscale_r;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic cfg_wr;

  logic [SUM_WIDTH-1:0] error_sum_r, error_sum_nxt;
  logic [ERR_W-1:0]     prev_err_r, prev_err_nxt;

  logic [DATA_W-1:0] fb_r, fb_nxt, tg_r, tg_nxt;
  logic [ERR_W-1:0]  emag_r, emag_nxt;
  logic [ERR_W-1:0]  demag_r, demag_nxt;
  logic [SPAD_W-1:0] s_shift_r, s_shift_nxt;
  logic p_neg_r, p_neg_nxt, i_neg_r, i_neg_nxt, d_neg_r, d_neg_nxt;
  logic [MUL_A_W-1:0] ki_r, ki_nxt, kd_r, kd_nxt;
  logic [IMAG_W-1:0]  imag_r, imag_nxt;
  logic [ACC_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  drive_r, drive_nxt;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic [ERR_W-1:0]       err;
  logic [DERR_W-1:0]      derr;
  logic [SUM_WIDTH:0]     sum_wide;
  logic [SUM_WIDTH-1:0]   sum_sat;
  logic [SUM_WIDTH-1:0]   sum_mag;
  logic                   imag_big;
  logic [IMAG_W:0]        imag_acc;
  logic [ACC_W-1:0]       term;
  logic                   term_neg;
  logic [ACC_W-1:0]       rnd;
  logic [ACC_W-FRAC_W-1:0] quot;
  logic [DATA_W-1:0]      q_sat;
  logic                   out_free;
  logic [DATA_W-1:0]      kp_mag, ki_mag, kd_mag;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_idx)
      REG_GAIN_P:           cfg_prdata = {{(CFG_DATA_W-DATA_W){1'b0}}, gain_p_r};
      REG_GAIN_I:           cfg_prdata = {{(CFG_DATA_W-DATA_W){1'b0}}, gain_i_r};
      REG_GAIN_D:           cfg_prdata = {{(CFG_DATA_W-DATA_W){1'b0}}, gain_d_r};
      REG_INTEGRAL_SCALE:   cfg_prdata = {{(CFG_DATA_W-DATA_W){1'b0}}, iscale_r};
      REG_DERIVATIVE_SCALE: cfg_prdata = {{(CFG_DATA_W-DATA_W){1'b0}}, dscale_r};
      default:              cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      iscale_r <= SCALE_RESET;
      dscale_r <= SCALE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_P:           gain_p_r <= cfg_pwdata[DATA_W-1:0];
        REG_GAIN_I:           gain_i_r <= cfg_pwdata[DATA_W-1:0];
        REG_GAIN_D:           gain_d_r <= cfg_pwdata[DATA_W-1:0];
        REG_INTEGRAL_SCALE:   iscale_r <= cfg_pwdata[DATA_W-1:0];
        REG_DERIVATIVE_SCALE: dscale_r <= cfg_pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive = drive_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL:    state_nxt = ST_KI;
      ST_KI:      state_nxt = ST_KD;
      ST_KD:      state_nxt = ST_PROP;
      ST_PROP:    state_nxt = ST_INTEG;
      ST_INTEG:   if (cnt_r == '0) state_nxt = ST_APPLY_I;
      ST_APPLY_I: state_nxt = ST_DERIV;
      ST_DERIV:   state_nxt = ST_FIN;
      ST_FIN:     if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Gain magnitudes are formed at 16 bits so that the most negative gain
  // yields 32768.
  assign kp_mag = gain_p_r[DATA_W-1] ? -gain_p_r : gain_p_r;
  assign ki_mag = gain_i_r[DATA_W-1] ? -gain_i_r : gain_i_r;
  assign kd_mag = gain_d_r[DATA_W-1] ? -gain_d_r : gain_d_r;

  // Shared multiplier operand selection.
  always_comb begin
    case (state_r)
      ST_KI: begin
        mul_a = MUL_A_W'(ki_mag);
        mul_b = MUL_B_W'(iscale_r);
      end
      ST_KD: begin
        mul_a = MUL_A_W'(kd_mag);
        mul_b = MUL_B_W'(dscale_r);
      end
      ST_PROP: begin
        mul_a = MUL_A_W'(kp_mag);
        mul_b = emag_r;
      end
      ST_INTEG: begin
        mul_a = ki_r;
        mul_b = MUL_B_W'(s_shift_r[SPAD_W-1 -: CHUNK_W]);
      end
      ST_DERIV: begin
        mul_a = kd_r;
        mul_b = demag_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Error, saturated sum and derivative from the latched request.
  assign err      = {tg_r[DATA_W-1], tg_r} - {fb_r[DATA_W-1], fb_r};
  assign derr     = {err[ERR_W-1], err} - {prev_err_r[ERR_W-1], prev_err_r};
  assign sum_wide = {error_sum_r[SUM_WIDTH-1], error_sum_r}
                  + {{(SUM_WIDTH+1-ERR_W){err[ERR_W-1]}}, err};

  always_comb begin
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
  end

  assign sum_mag = sum_sat[SUM_WIDTH-1] ? -sum_sat : sum_sat;

  // Integral magnitude is built from the top chunk down and clamped at 2^60.
  assign imag_big = |imag_r[IMAG_W-1:CLAMP_EXP-CHUNK_W];
  assign imag_acc = (IMAG_W+1)'({imag_r[CLAMP_EXP-CHUNK_W-1:0], {CHUNK_W{1'b0}}})
                  + (IMAG_W+1)'(prod);

  // Signed term added to the running total.
  always_comb begin
    case (state_r)
      ST_PROP: begin
        term     = ACC_W'(prod) << P_SHIFT;
        term_neg = p_neg_r;
      end
      ST_APPLY_I: begin
        term     = ACC_W'(imag_r);
        term_neg = i_neg_r;
      end
      ST_DERIV: begin
        term     = ACC_W'(prod);
        term_neg = d_neg_r;
      end
      default: begin
        term     = '0;
        term_neg = 1'b0;
      end
    endcase
  end

  // Truncation toward zero and output saturation.
  assign rnd  = total_r + (total_r[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
  assign quot = rnd[ACC_W-1:FRAC_W];

  always_comb begin
    if (quot[ACC_W-FRAC_W-1:DATA_W-1] == '0 || quot[ACC_W-FRAC_W-1:DATA_W-1] == '1) begin
      q_sat = quot[DATA_W-1:0];
    end else begin
      q_sat = quot[ACC_W-FRAC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                   : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // Datapath next values.
  always_comb begin
    fb_nxt        = fb_r;
    tg_nxt        = tg_r;
    error_sum_nxt = error_sum_r;
    prev_err_nxt  = prev_err_r;
    emag_nxt      = emag_r;
    demag_nxt     = demag_r;
    s_shift_nxt   = s_shift_r;
    p_neg_nxt     = p_neg_r;
    i_neg_nxt     = i_neg_r;
    d_neg_nxt     = d_neg_r;
    ki_nxt        = ki_r;
    kd_nxt        = kd_r;
    imag_nxt      = imag_r;
    total_nxt     = total_r;
    cnt_nxt       = cnt_r;
    drive_nxt     = drive_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (term_neg) begin
      total_nxt = total_r - term;
    end else begin
      total_nxt = total_r + term;
    end
    case (state_r)
      ST_IDLE: begin
        fb_nxt = in_feedback;
        tg_nxt = in_target;
      end
      ST_EVAL: begin
        error_sum_nxt = sum_sat;
        prev_err_nxt  = err;
        emag_nxt      = err[ERR_W-1] ? -err : err;
        demag_nxt     = derr[DERR_W-1] ? ERR_W'(-derr) : derr[ERR_W-1:0];
        s_shift_nxt   = SPAD_W'(sum_mag);
        p_neg_nxt     = gain_p_r[DATA_W-1] ^ err[ERR_W-1];
        i_neg_nxt     = gain_i_r[DATA_W-1] ^ sum_sat[SUM_WIDTH-1];
        d_neg_nxt     = gain_d_r[DATA_W-1] ^ derr[DERR_W-1];
        total_nxt     = '0;
      end
      ST_KI: ki_nxt = prod[MUL_A_W-1:0];
      ST_KD: kd_nxt = prod[MUL_A_W-1:0];
      ST_PROP: begin
        imag_nxt = '0;
        cnt_nxt  = CNT_W'(SUM_CHUNKS - 1);
      end
      ST_INTEG: begin
        if (imag_big || imag_acc > (IMAG_W+1)'(1) << CLAMP_EXP) begin
          imag_nxt = IMAG_W'(1) << CLAMP_EXP;
        end else begin
          imag_nxt = imag_acc[IMAG_W-1:0];
        end
        s_shift_nxt = s_shift_r << CHUNK_W;
        cnt_nxt     = cnt_r - CNT_W'(1);
      end
      ST_FIN: begin
        if (out_free) begin
          drive_nxt     = q_sat;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      error_sum_r <= '0;
      prev_err_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      error_sum_r <= error_sum_nxt;
      prev_err_r  <= prev_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fb_r      <= fb_nxt;
    tg_r      <= tg_nxt;
    emag_r    <= emag_nxt;
    demag_r   <= demag_nxt;
    s_shift_r <= s_shift_nxt;
    p_neg_r   <= p_neg_nxt;
    i_neg_r   <= i_neg_nxt;
    d_neg_r   <= d_neg_nxt;
    ki_r      <= ki_nxt;
    kd_r      <= kd_nxt;
    imag_r    <= imag_nxt;
    total_r   <= total_nxt;
    cnt_r     <= cnt_nxt;
    drive_r   <= drive_nxt;
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ppid_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 1700;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES = 40;
  localparam int PLAN_ROWS = 33;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_IDX_W'(5);
  localparam longint unsigned TERM_LIMIT = 64'd1 << CLAMP_EXP;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [31:0] value;
    logic signed [15:0] feedback;
    logic signed [15:0] target;
    logic pinned;
    logic signed [15:0] drive;
  } plan_row_t;

  typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_TOGGLE} sink_mode_t;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'h8000, 16'h7fff, 1'b1, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'h7fff, 16'h8000, 1'b1, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'd0, 16'd0, 1'b1, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, -16'sd1, -16'sd1, 1'b1, 16'd0},
    '{ROW_WRITE, REG_GAIN_P, 32'd256, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'sd0, 16'sd5, 1'b1, 16'sd5},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'sd3, 16'sd0, 1'b1, -16'sd3},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'h8000, 16'h7fff, 1'b1, 16'h7fff},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'h7fff, 16'h8000, 1'b1, 16'h8000},
    '{ROW_WRITE, REG_GAIN_P, 32'd128, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'sd0, -16'sd3, 1'b1, -16'sd1},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'sd0, 16'sd3, 1'b1, 16'sd1},
    '{ROW_WRITE, REG_GAIN_P, 32'h0000_8000, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'sd0, 16'sd1, 1'b1, -16'sd128},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'sd0, -16'sd300, 1'b1, 16'h7fff},
    '{ROW_WRITE, REG_GAIN_P, 32'd32767, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'sd0, -16'sd1, 1'b1, -16'sd127},
    '{ROW_WRITE, REG_GAIN_P, 32'd0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_GAIN_D, 32'd256, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'sd0, 16'sd10, 1'b1, 16'sd11},
    '{ROW_WRITE, REG_DERIVATIVE_SCALE, 32'd0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'sd0, -16'sd10, 1'b1, 16'sd0},
    '{ROW_WRITE, REG_GAIN_D, 32'd32767, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_DERIVATIVE_SCALE, 32'd65535, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'h8000, 16'h7fff, 1'b0, 16'd0},
    '{ROW_WRITE, REG_GAIN_D, 32'd0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_GAIN_I, 32'h0000_8000, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_INTEGRAL_SCALE, 32'd65535, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'sd0, 16'sd12345, 1'b0, 16'd0},
    '{ROW_WRITE, REG_INTEGRAL_SCALE, 32'd0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, 16'sd5, 16'sd5, 1'b1, 16'sd0},
    '{ROW_WRITE, REG_UNMAPPED, 32'hffff_ffff, 16'd0, 16'd0, 1'b0, 16'd0},
    '{ROW_ITEM, REG_GAIN_P, 32'd0, -16'sd7, 16'sd9, 1'b1, 16'sd0}
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_feedback;
  logic signed [15:0] in_target;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_drive;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  logic drive_pinned;
  logic signed [15:0] pinned_drive;
  bit hold_request;
  bit fast_mode;
  int mismatches;
  int idle_cycles;

  logic signed [15:0] kp;
  logic signed [15:0] ki;
  logic signed [15:0] kd;
  logic [15:0] ki_scale;
  logic [15:0] kd_scale;
  logic signed [SUM_WIDTH-1:0] err_sum;
  logic signed [ERR_W-1:0] last_err;

  logic signed [15:0] pending_drive [$];

  positional_pid_controller_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_feedback(in_feedback),
    .in_target(in_target),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_drive(out_drive),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic signed [15:0] next_drive(input logic signed [15:0] fb,
                                                    input logic signed [15:0] tg);
    longint e, s, de, k, iterm, total, q, sum_max, sum_min;
    longint unsigned mk, ms, mprod;
    sum_max = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    sum_min = -sum_max - 1;
    e = longint'(tg) - longint'(fb);
    s = longint'(err_sum) + e;
    if (s > sum_max) begin
      s = sum_max;
    end else if (s < sum_min) begin
      s = sum_min;
    end
    de = e - longint'(last_err);
    err_sum = s[SUM_WIDTH-1:0];
    last_err = e[ERR_W-1:0];
    k = longint'(ki) * longint'(ki_scale);
    mk = (k < 0) ? -k : k;
    ms = (s < 0) ? -s : s;
    if (mk == 0 || ms == 0) begin
      mprod = 0;
    end else if (mk > TERM_LIMIT / ms) begin
      mprod = TERM_LIMIT;
    end else begin
      mprod = mk * ms;
      if (mprod > TERM_LIMIT) mprod = TERM_LIMIT;
    end
    iterm = ((k < 0) != (s < 0)) ? -longint'(mprod) : longint'(mprod);
    total = longint'(kp) * e * 256 + iterm + longint'(kd) * longint'(kd_scale) * de;
    q = total / 65536;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  always @(posedge clk) begin : monitor
    logic signed [15:0] want;
    logic signed [15:0] model_drive;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_drive.size() == 0) begin
          if (mismatches < MAX_REPORTS) $display("unexpected drive %0d", out_drive);
          mismatches++;
        end else begin
          want = pending_drive.pop_front();
          if (out_drive !== want) begin
            if (mismatches < MAX_REPORTS) begin
              $display("drive mismatch: expected %0d, got %0d", want, out_drive);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        model_drive = next_drive(in_feedback, in_target);
        pending_drive.push_back(drive_pinned ? pinned_drive : model_drive);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("** positional_pid_controller_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    sink_mode_t mode;
    int span;
    int hold_len;
    out_stall = 1'b0;
    mode = SINK_FREE;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_len = $urandom_range(200, 400);
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (fast_mode) begin
        out_stall <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          span = $urandom_range(10, 120);
        end
        span--;
        case (mode)
          SINK_FREE: out_stall <= 1'b0;
          SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          SINK_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic offer(input logic signed [15:0] fb, input logic signed [15:0] tg,
                       input logic pin, input logic signed [15:0] pin_drive);
    in_valid <= 1'b1;
    in_feedback <= fb;
    in_target <= tg;
    drive_pinned <= pin;
    pinned_drive <= pin_drive;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic quiesce();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(idx) << 2;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_GAIN_P: kp = value[15:0];
      REG_GAIN_I: ki = value[15:0];
      REG_GAIN_D: kd = value[15:0];
      REG_INTEGRAL_SCALE: ki_scale = value[15:0];
      REG_DERIVATIVE_SCALE: kd_scale = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'($urandom());
      1, 2, 3: return 16'($urandom_range(0, 1024)) - 16'd512;
      4: return ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7fff;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return SCALE_RESET;
      2: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hffff;
      default: return 16'($urandom_range(0, 1024));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_edge();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic retune();
    quiesce();
    cfg_write(REG_GAIN_P, {16'($urandom()), pick_gain()});
    cfg_write(REG_GAIN_I, {16'($urandom()), pick_gain()});
    cfg_write(REG_GAIN_D, {16'($urandom()), pick_gain()});
    cfg_write(REG_INTEGRAL_SCALE, {16'($urandom()), pick_scale()});
    cfg_write(REG_DERIVATIVE_SCALE, {16'($urandom()), pick_scale()});
  endtask

  task automatic offer_random();
    logic signed [15:0] fb;
    logic signed [15:0] tg;
    fb = 16'($urandom());
    tg = 16'($urandom());
    case ($urandom_range(0, 3))
      0: ;
      1: tg = fb + 16'($urandom_range(0, 128)) - 16'd64;
      2: begin
        fb = 16'($urandom_range(0, 400)) - 16'd200;
        tg = 16'($urandom_range(0, 400)) - 16'd200;
      end
      default: begin
        fb = pick_edge();
        tg = pick_edge();
      end
    endcase
    offer(fb, tg, 1'b0, 16'd0);
  endtask

  task automatic set_integral(input logic [31:0] gain, input logic [31:0] scale);
    quiesce();
    cfg_write(REG_GAIN_I, gain);
    cfg_write(REG_INTEGRAL_SCALE, scale);
  endtask

  initial begin : stimulus
    int n;
    int burst_left;
    int wind;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_feedback = '0;
    in_target = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    drive_pinned = 1'b0;
    pinned_drive = '0;
    hold_request = 1'b0;
    fast_mode = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    kp = '0;
    ki = '0;
    kd = '0;
    ki_scale = SCALE_RESET;
    kd_scale = SCALE_RESET;
    err_sum = '0;
    last_err = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_WRITE) begin
        quiesce();
        cfg_write(PLAN[r].reg_idx, PLAN[r].value);
      end else begin
        offer(PLAN[r].feedback, PLAN[r].target, PLAN[r].pinned, PLAN[r].drive);
      end
    end

    if (SUM_WIDTH <= 24) begin
      wind = int'((longint'(1) <<< (SUM_WIDTH - 1)) / 65535) + 3;
      fast_mode = 1'b1;
      quiesce();
      cfg_write(REG_GAIN_P, 32'd0);
      cfg_write(REG_GAIN_D, 32'd0);
      set_integral(32'd1, 32'd1);
      repeat (wind) offer(16'h8000, 16'h7fff, 1'b0, 16'd0);
      set_integral(32'h0000_8000, 32'd65535);
      repeat (3) offer(16'd0, 16'd0, 1'b0, 16'd0);
      set_integral(32'd1, 32'd1);
      repeat (2 * wind) offer(16'h7fff, 16'h8000, 1'b0, 16'd0);
      set_integral(32'h0000_8000, 32'd65535);
      repeat (3) offer(16'd0, 16'd0, 1'b0, 16'd0);
      fast_mode = 1'b0;
    end

    burst_left = 1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 0) retune();
      if (n == 700) begin
        hold_request = 1'b1;
        burst_left = 80;
      end
      if (n == 1100) quiesce();
      offer_random();
      burst_left--;
      if (burst_left == 0) begin
        pause(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12));
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 90)
                                                 : $urandom_range(1, 12);
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_drive.size() == 0) begin
      $display("** positional_pid_controller_top: PASSED **");
    end else begin
      $display("** positional_pid_controller_top: FAILED **");
    end
    $finish;
  end

endmodule
